>>> rtl/msp_pkg.sv
// Shared types and constants of the MSP response deframer.
package msp_pkg;

	localparam logic [7:0] SYNC_DOLLAR     = 8'h24;
	localparam logic [7:0] SYNC_M          = 8'h4D;
	localparam logic [7:0] DIRECTION_RESET = 8'h3E;

	localparam logic [1:0] STATUS_GOOD = 2'd0;
	localparam logic [1:0] STATUS_CSUM = 2'd1;
	localparam logic [1:0] STATUS_OVER = 2'd2;

	localparam logic REG_DIRECTION = 1'b0;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] command;
		logic [7:0] size;
	} frame_desc_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic store_busy;
		logic push;
	} front_status_t;

endpackage

>>> rtl/msp_if.sv
// Channel interfaces: received byte beats and result beats.
interface msp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface msp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] command;
	logic [7:0] payload_size;
	logic [5:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output status, output command, output payload_size,
		output byte_index, output payload_byte, output last, input ready);
	modport sink (input valid, input status, input command, input payload_size,
		input byte_index, input payload_byte, input last, output ready);
endinterface

>>> rtl/msp_response_deframer.sv
// Top level of the MSP response deframer: parser, descriptor queue, replay, register.
//
// channel  dir  beat contents
// rx       in   rx_byte: one received serial byte
// res      out  status, command, payload_size, byte_index, payload_byte, last
// apb      in   direction_byte at address 0
//
// Header and payload bytes are taken one per cycle; the parser holds off a payload
// byte while the store still holds a good frame awaiting replay, and the checksum
// byte while the descriptor queue is full. Replay takes a descriptor in IDLE, reads
// each payload byte in LOAD and outputs it in SHOW; error and empty frames skip LOAD.
// Reset is asynchronous and clears control state only; the store needs no clearing.
// A stalled beat holds; the parser reads on behind it until queue full or store busy.
module msp_response_deframer import msp_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	msp_byte_if.sink     rx,
	msp_result_if.source res,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [7:0]    direction_q;
	logic          q_push;
	logic          q_not_full;
	logic          q_pop;
	logic          q_not_empty;
	frame_desc_t   push_desc;
	frame_desc_t   pop_desc;
	store_wr_t     wr;
	logic          replay_done;
	front_status_t front_stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIRECTION) ? {24'h000000, direction_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIRECTION_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION)) begin
			direction_q <= pwdata[7:0];
		end
	end

	msp_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.direction   (direction_q),
		.q_ready     (q_not_full),
		.q_push      (q_push),
		.q_desc      (push_desc),
		.wr          (wr),
		.replay_done (replay_done),
		.stat        (front_stat)
	);

	msp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_desc  (pop_desc)
	);

	msp_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.q_valid     (q_not_empty),
		.q_desc      (pop_desc),
		.q_pop       (q_pop),
		.res         (res),
		.replay_done (replay_done)
	);

	a_no_write_during_replay: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !front_stat.store_busy)
		else $error("payload store written while a frame awaits replay");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.push |-> q_not_full)
		else $error("descriptor pushed into a full queue");

	a_release_after_replay: assert property (@(posedge clk) disable iff (!arst_n)
		replay_done |=> !front_stat.store_busy)
		else $error("store still held after its last replay beat");

endmodule

>>> rtl/msp_front.sv
// Header hunter and frame parser: stores payload, queues one descriptor per frame.
module msp_front import msp_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	msp_byte_if.sink      rx,
	input  logic [7:0]    direction,
	input  logic          q_ready,
	output logic          q_push,
	output frame_desc_t   q_desc,
	output store_wr_t     wr,
	input  logic          replay_done,
	output front_status_t stat
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [7:0] DEPTH8 = 8'(PAYLOAD_DEPTH);

	typedef enum logic [2:0] {
		IDLE, GOT_DOLLAR, GOT_M, GOT_DIR, GOT_SIZE, PAYLOAD
	} state_t;

	state_t     state_q;
	logic [7:0] size_q;
	logic [7:0] command_q;
	logic [7:0] xor_q;
	logic [7:0] count_q;
	logic       busy_q;
	logic       accept;
	logic       at_end;
	logic [7:0] xor_next;

	assign at_end   = (count_q == size_q);
	assign xor_next = xor_q ^ rx.rx_byte;
	assign rx.ready = !((state_q == PAYLOAD) && (at_end ? !q_ready : busy_q));
	assign accept   = rx.valid && rx.ready;

	assign q_push = accept && (state_q == PAYLOAD) && at_end;

	always_comb begin
		q_desc.command = command_q;
		q_desc.size    = size_q;
		if (size_q > DEPTH8) begin
			q_desc.status = STATUS_OVER;
		end else if (xor_next != 8'h00) begin
			q_desc.status = STATUS_CSUM;
		end else begin
			q_desc.status = STATUS_GOOD;
		end
	end

	always_comb begin
		wr.en   = accept && (state_q == PAYLOAD) && !at_end && (count_q < DEPTH8);
		wr.addr = 6'(count_q[AW-1:0]);
		wr.data = rx.rx_byte;
	end

	assign stat.store_busy = busy_q;
	assign stat.push       = q_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			size_q    <= 8'h00;
			command_q <= 8'h00;
			xor_q     <= 8'h00;
			count_q   <= 8'h00;
			busy_q    <= 1'b0;
		end else begin
			if (replay_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				case (state_q)
					GOT_DOLLAR: begin
						state_q <= (rx.rx_byte == SYNC_M) ? GOT_M : IDLE;
					end
					GOT_M: begin
						state_q <= (rx.rx_byte == direction) ? GOT_DIR : IDLE;
					end
					GOT_DIR: begin
						size_q  <= rx.rx_byte;
						xor_q   <= rx.rx_byte;
						state_q <= GOT_SIZE;
					end
					GOT_SIZE: begin
						command_q <= rx.rx_byte;
						xor_q     <= xor_next;
						count_q   <= 8'h00;
						state_q   <= PAYLOAD;
					end
					PAYLOAD: begin
						xor_q <= xor_next;
						if (at_end) begin
							if ((q_desc.status == STATUS_GOOD) && (size_q != 8'h00)) begin
								busy_q <= 1'b1;
							end
							state_q <= IDLE;
						end else begin
							count_q <= count_q + 8'd1;
						end
					end
					default: begin
						state_q <= (rx.rx_byte == SYNC_DOLLAR) ? GOT_DOLLAR : IDLE;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/msp_queue.sv
// Two-entry descriptor queue between parser and replay.
module msp_queue import msp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	output logic        not_full,
	input  logic        pop,
	output logic        not_empty,
	output frame_desc_t pop_desc
);

	frame_desc_t entry_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_desc  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/msp_back.sv
// Payload store and replay: turns each descriptor into its run of result beats.
module msp_back import msp_pkg::*; #(
	parameter int PAYLOAD_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_wr_t     wr,
	input  logic          q_valid,
	input  frame_desc_t   q_desc,
	output logic          q_pop,
	msp_result_if.source  res,
	output logic          replay_done
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	typedef enum logic [1:0] {
		IDLE, LOAD, SHOW
	} state_t;

	logic [7:0]  mem [PAYLOAD_DEPTH];
	logic [7:0]  rd_data_q;
	state_t      state_q;
	frame_desc_t desc_q;
	logic        replay_q;
	logic [5:0]  idx_q;
	logic        last_c;
	logic        beat;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	assign last_c = replay_q ? (({2'b00, idx_q} + 8'd1) == desc_q.size) : 1'b1;
	assign q_pop  = (state_q == IDLE) && q_valid;
	assign beat   = res.valid && res.ready;

	assign res.valid        = (state_q == SHOW);
	assign res.status       = desc_q.status;
	assign res.command      = desc_q.command;
	assign res.payload_size = desc_q.size;
	assign res.byte_index   = idx_q;
	assign res.payload_byte = replay_q ? rd_data_q : 8'h00;
	assign res.last         = last_c;
	assign replay_done      = beat && last_c && replay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			desc_q   <= '0;
			replay_q <= 1'b0;
			idx_q    <= 6'd0;
		end else begin
			case (state_q)
				IDLE: begin
					if (q_valid) begin
						desc_q   <= q_desc;
						idx_q    <= 6'd0;
						replay_q <= (q_desc.status == STATUS_GOOD) && (q_desc.size != 8'h00);
						if ((q_desc.status == STATUS_GOOD) && (q_desc.size != 8'h00)) begin
							state_q <= LOAD;
						end else begin
							state_q <= SHOW;
						end
					end
				end
				LOAD: begin
					state_q <= SHOW;
				end
				SHOW: begin
					if (beat) begin
						if (last_c) begin
							state_q <= IDLE;
						end else begin
							idx_q   <= idx_q + 6'd1;
							state_q <= LOAD;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/tb_msp_response_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench of the MSP response deframer: byte stream in, frame results out.
module tb_msp_response_deframer;
	import msp_pkg::*;

	localparam int PAYLOAD_DEPTH = 64;
	localparam int SETTLE_CYCLES = 2 * PAYLOAD_DEPTH + 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 500;

	typedef enum logic [2:0] {
		P_HUNT, P_DOLLAR, P_M, P_DIR, P_SIZE, P_BODY
	} parse_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] command;
		logic [7:0] size;
		logic [5:0] index;
		logic [7:0] data;
		logic       last;
	} result_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	msp_byte_if   rx_ch();
	msp_result_if res_ch();

	msp_response_deframer #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Stream side
	logic [7:0]   rx_pending[$];
	int           bytes_pushed = 0;
	int           bytes_taken = 0;
	bit           rx_took = 0;
	int           src_idle = 8;
	int           sink_idle = 85;
	int           hold_req = 0;
	int           hold_seen = 0;
	int           hold_left = 0;
	logic [7:0]   dir_now = DIRECTION_RESET;
	int           mismatches = 0;
	int           cycle_cnt = 0;
	result_beat_t frame_beats_due[$];

	// Frame parser copy
	parse_t     p_state = P_HUNT;
	logic [7:0] p_dir = DIRECTION_RESET;
	logic [7:0] p_size = '0;
	logic [7:0] p_cmd = '0;
	logic [7:0] p_xor = '0;
	logic [7:0] p_count = '0;
	logic [7:0] p_store[PAYLOAD_DEPTH];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void queue_result(logic [1:0] status, logic [5:0] index,
		logic [7:0] data, logic last);
		result_beat_t b;
		b.status = status;
		b.command = p_cmd;
		b.size = p_size;
		b.index = index;
		b.data = data;
		b.last = last;
		frame_beats_due.push_back(b);
	endfunction

	function automatic void parse_rx_byte(logic [7:0] c);
		case (p_state)
			P_DOLLAR: p_state = (c == SYNC_M) ? P_M : P_HUNT;
			P_M: p_state = (c == p_dir) ? P_DIR : P_HUNT;
			P_DIR: begin
				p_size = c;
				p_xor = c;
				p_state = P_SIZE;
			end
			P_SIZE: begin
				p_cmd = c;
				p_xor ^= c;
				p_count = '0;
				p_state = P_BODY;
			end
			P_BODY: begin
				p_xor ^= c;
				if (p_count == p_size) begin
					if (p_size > PAYLOAD_DEPTH)
						queue_result(STATUS_OVER, 6'd0, 8'd0, 1'b1);
					else if (p_xor != 8'd0)
						queue_result(STATUS_CSUM, 6'd0, 8'd0, 1'b1);
					else if (p_size == 8'd0)
						queue_result(STATUS_GOOD, 6'd0, 8'd0, 1'b1);
					else
						for (int i = 0; i < p_size; i++)
							queue_result(STATUS_GOOD, 6'(i), p_store[i], (i + 1 == p_size));
					p_state = P_HUNT;
				end else begin
					if (p_count < PAYLOAD_DEPTH)
						p_store[p_count] = c;
					p_count = p_count + 8'd1;
				end
			end
			default: p_state = (c == SYNC_DOLLAR) ? P_DOLLAR : P_HUNT;
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Byte driver
	always @(negedge clk) begin
		if (rx_ch.valid && !rx_took) begin
			// hold the beat until taken
		end else if (rx_pending.size() != 0 && $urandom_range(99) >= src_idle) begin
			rx_ch.valid <= 1'b1;
			rx_ch.rx_byte <= rx_pending.pop_front();
		end else begin
			rx_ch.valid <= 1'b0;
		end
	end

	// Result receiver
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// Monitor
	always @(posedge clk) begin : monitor
		result_beat_t want;
		rx_took = rx_ch.valid && rx_ch.ready;
		if (rx_took) begin
			parse_rx_byte(rx_ch.rx_byte);
			bytes_taken++;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (frame_beats_due.size() == 0) begin
				$error("result beat with nothing due: status %0h command %0h",
					res_ch.status, res_ch.command);
				mismatches++;
			end else begin
				want = frame_beats_due.pop_front();
				check_field("status", 8'(want.status), 8'(res_ch.status));
				check_field("command", want.command, res_ch.command);
				check_field("payload_size", want.size, res_ch.payload_size);
				check_field("byte_index", 8'(want.index), 8'(res_ch.byte_index));
				check_field("payload_byte", want.data, res_ch.payload_byte);
				check_field("last", 8'(want.last), 8'(res_ch.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_msp_response_deframer NOT OK");
			$finish;
		end
	end

	task automatic push_byte(logic [7:0] b);
		rx_pending.push_back(b);
		bytes_pushed++;
	endtask

	task automatic push_frame(int size, bit bad_csum);
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] d;
		cmd = 8'($urandom_range(255));
		sum = 8'(size) ^ cmd;
		push_byte(SYNC_DOLLAR);
		push_byte(SYNC_M);
		push_byte(dir_now);
		push_byte(8'(size));
		push_byte(cmd);
		for (int i = 0; i < size; i++) begin
			d = 8'($urandom_range(255));
			sum ^= d;
			push_byte(d);
		end
		if (bad_csum)
			sum ^= 8'($urandom_range(1, 255));
		push_byte(sum);
	endtask

	task automatic random_traffic(int budget);
		int start;
		int pick;
		int size;
		logic [7:0] wrong;
		start = bytes_pushed;
		while (bytes_pushed - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				size = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
				push_frame(size, $urandom_range(9) == 0);
			end else if (pick < 88) begin
				push_byte(SYNC_DOLLAR);
				if ($urandom_range(1)) begin
					wrong = $urandom_range(1) ? SYNC_DOLLAR : 8'($urandom_range(255));
					if (wrong == SYNC_M)
						wrong = ~wrong;
					push_byte(wrong);
				end else begin
					push_byte(SYNC_M);
					push_byte(dir_now ^ 8'($urandom_range(1, 255)));
				end
			end else begin
				push_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic drain();
		while (bytes_taken != bytes_pushed || frame_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_DIRECTION, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		dir_now = v;
		p_dir = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [7:0] directed[] = '{
			SYNC_DOLLAR, SYNC_DOLLAR, SYNC_M, DIRECTION_RESET,
			SYNC_DOLLAR, SYNC_M, 8'h3C,
			SYNC_DOLLAR, SYNC_M, DIRECTION_RESET, 8'h00, 8'h00, 8'h00,
			SYNC_DOLLAR, SYNC_M, DIRECTION_RESET, 8'h01, 8'hFF, 8'hFF, 8'h01,
			SYNC_DOLLAR, SYNC_M, DIRECTION_RESET, 8'h02, 8'h80, 8'h00, 8'h7F, 8'h00
		};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_direction(DIRECTION_RESET);
		foreach (directed[i])
			push_byte(directed[i]);
		random_traffic(20);
		drain();

		src_idle = 85;
		sink_idle = 8;
		write_direction(8'h00);
		random_traffic(20);
		drain();

		src_idle = 0;
		sink_idle = 0;
		write_direction(8'hFF);
		random_traffic(10);
		drain();
		hold_req++;
		repeat (2) push_frame($urandom_range(1, 4), 1'b0);
		push_frame(PAYLOAD_DEPTH + 1, 1'b1);
		drain();

		write_direction(8'($urandom_range(255)));
		random_traffic(10);
		drain();

		if (mismatches == 0 && frame_beats_due.size() == 0)
			$display("tb_msp_response_deframer OK");
		else
			$display("tb_msp_response_deframer NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/msp_pkg.sv
rtl/msp_if.sv
rtl/msp_front.sv
rtl/msp_queue.sv
rtl/msp_back.sv
rtl/msp_response_deframer.sv
sim/tb_msp_response_deframer.sv
